[hdl/hvlrd_pkg.sv]
// ---------------------------------------------------------------------------
// hvlrd_pkg: shared types and constants for the line-run detector
// Sizes, register codes, queue word and result word formats.
// ---------------------------------------------------------------------------
package hvlrd_pkg;

   // Frame limits and field widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int POS_W      = 10;
   localparam int CNT_W      = 11;
   localparam int PIX_W      = 8;
   localparam int COL_AW     = $clog2(MAX_WIDTH);

   localparam logic [CNT_W-1:0] CNT_MAX      = '1;
   localparam logic [CNT_W-1:0] WIDTH_LIMIT  = CNT_W'(MAX_WIDTH);
   localparam logic [CNT_W-1:0] HEIGHT_LIMIT = CNT_W'(MAX_HEIGHT);
   localparam logic [PIX_W-1:0] SET_PIXEL    = 8'hFF;

   // Register reset values
   localparam logic [CNT_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [CNT_W-1:0] FRAME_HEIGHT_RST = 11'd480;
   localparam logic [CNT_W-1:0] H_MIN_RUN_RST    = 11'd20;
   localparam logic [CNT_W-1:0] V_MIN_RUN_RST    = 11'd15;

   // Result buffer sizing
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);
   localparam logic [OUT_LW-1:0] OUT_ROOM = OUT_LW'(OUT_DEPTH - 2);

   typedef enum logic {
      DIR_HORZ = 1'b0,
      DIR_VERT = 1'b1
   } dir_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_H_MIN_RUN    = 2'd2,
      CSR_V_MIN_RUN    = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [CNT_W-1:0] frame_width;
      logic [CNT_W-1:0] frame_height;
      logic [CNT_W-1:0] h_min_run;
      logic [CNT_W-1:0] v_min_run;
   } cfg_type;

   // Classified pixel, front to back
   typedef struct packed {
      logic             set;
      logic             h_emit;
      logic [POS_W-1:0] h_start;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last_row;
   } item_type;

   typedef struct packed {
      dir_type          direction;
      logic [POS_W-1:0] line_index;
      logic [POS_W-1:0] run_start;
      logic [POS_W-1:0] run_stop;
      logic             last;
   } result_type;

   typedef struct packed {
      logic              busy;
      logic [OUT_LW-1:0] out_level;
   } bk_status_type;

   // Clamp a frame size into 1..limit
   function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] limit);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > limit) begin
         r = limit;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[hdl/hvlrd_front.sv]
// ---------------------------------------------------------------------------
// hvlrd_front: pixel intake and classification
// Tracks raster position and the horizontal run, decides horizontal
// segments and hands each word to the queue.
// ---------------------------------------------------------------------------
module hvlrd_front import hvlrd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] in_pixel,
   output logic             in_stall,
   input  logic             busy,
   input  logic             q_full,
   output logic             q_push,
   output item_type         q_item
);

   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] h_cnt_ff, h_cnt_in;

   logic [CNT_W-1:0] width_c;
   logic [CNT_W-1:0] height_c;
   logic [CNT_W-1:0] col_ext;
   logic [CNT_W-1:0] row_ext;
   logic             last_col;
   logic             last_row;
   logic             set;
   logic             accept;

   // Hold off while the column memory clears or the queue is full
   assign in_stall = busy || q_full;
   assign accept   = in_valid && !in_stall;
   assign q_push   = accept;

   // Classify the pixel at the current position
   always_comb begin
      width_c  = clamp_size(cfg.frame_width, WIDTH_LIMIT);
      height_c = clamp_size(cfg.frame_height, HEIGHT_LIMIT);
      col_ext  = CNT_W'(col_ff);
      row_ext  = CNT_W'(row_ff);
      last_col = (col_ext + CNT_W'(1)) >= width_c;
      last_row = (row_ext + CNT_W'(1)) >= height_c;
      set      = in_pixel == SET_PIXEL;

      q_item.set      = set;
      q_item.h_emit   = !set && (h_cnt_ff >= cfg.h_min_run);
      q_item.h_start  = (h_cnt_ff > col_ext) ? '0 : POS_W'(col_ext - h_cnt_ff);
      q_item.row      = row_ff;
      q_item.col      = col_ff;
      q_item.last_row = last_row;
   end

   // Advance position and horizontal run
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      h_cnt_in = h_cnt_ff;
      if (accept) begin
         if (!set) begin
            h_cnt_in = '0;
         end else if (h_cnt_ff != CNT_MAX) begin
            h_cnt_in = h_cnt_ff + CNT_W'(1);
         end
         if (last_col) begin
            h_cnt_in = '0;
            col_in   = '0;
            row_in   = last_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         h_cnt_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         h_cnt_ff <= h_cnt_in;
      end
   end

endmodule

[hdl/hvlrd_queue.sv]
// ---------------------------------------------------------------------------
// hvlrd_queue: two-word queue between front and back
// Lets the front keep taking pixels while the back waits on output room.
// ---------------------------------------------------------------------------
module hvlrd_queue import hvlrd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_item  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/hvlrd_back.sv]
// ---------------------------------------------------------------------------
// hvlrd_back: vertical runs and result output
// Reads the column counter, updates it in the cycle after with forwarding,
// decides vertical segments and buffers up to two results per pixel.
// ---------------------------------------------------------------------------
module hvlrd_back import hvlrd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] v_min_run,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output bk_status_type    status,
   output logic             out_valid,
   input  logic             out_stall,
   output result_type       out_word
);

   // Column counter memory and clearing sweep
   logic [CNT_W-1:0]  vmem [MAX_WIDTH];
   logic [CNT_W-1:0]  mem_rd_ff;
   logic              busy_ff, busy_in;
   logic [COL_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              mem_we;
   logic [COL_AW-1:0] mem_waddr;
   logic [CNT_W-1:0]  mem_wdata;
   logic [COL_AW-1:0] mem_raddr;

   // Last item write, for a read issued in the same cycle
   logic              fwd_valid_ff;
   logic [COL_AW-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]  fwd_data_ff;

   // Execute stage
   logic              e_valid_ff;
   item_type          e_item_ff;
   logic [COL_AW-1:0] e_addr;
   logic [CNT_W-1:0]  v_cnt;
   logic [CNT_W-1:0]  v_cnt_new;
   logic [CNT_W-1:0]  row_ext;
   logic              v_emit;
   logic              h_emit;
   result_type        h_word;
   result_type        v_word;

   // Result buffer
   result_type        out_mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_LW-1:0] out_cnt_ff, out_cnt_in;
   logic [1:0]        n_push;
   logic              out_pop;

   assign status.busy      = busy_ff;
   assign status.out_level = out_cnt_ff;

   // Sweep the memory to zero after reset
   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + COL_AW'(1);
         if (clr_cnt_ff == COL_AW'(MAX_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Update the column counter of the executing pixel
   always_comb begin
      e_addr  = COL_AW'(e_item_ff.col);
      v_cnt   = (fwd_valid_ff && (fwd_addr_ff == e_addr)) ? fwd_data_ff : mem_rd_ff;
      row_ext = CNT_W'(e_item_ff.row);
      if (!e_item_ff.set || e_item_ff.last_row) begin
         v_cnt_new = '0;
      end else if (v_cnt != CNT_MAX) begin
         v_cnt_new = v_cnt + CNT_W'(1);
      end else begin
         v_cnt_new = v_cnt;
      end
      v_emit = e_valid_ff && !e_item_ff.set && (v_cnt >= v_min_run);
      h_emit = e_valid_ff && e_item_ff.h_emit;

      h_word.direction  = DIR_HORZ;
      h_word.line_index = e_item_ff.row;
      h_word.run_start  = e_item_ff.h_start;
      h_word.run_stop   = e_item_ff.col;
      h_word.last       = !v_emit;

      v_word.direction  = DIR_VERT;
      v_word.line_index = e_item_ff.col;
      v_word.run_start  = (v_cnt > row_ext) ? '0 : POS_W'(row_ext - v_cnt);
      v_word.run_stop   = e_item_ff.row;
      v_word.last       = 1'b1;

      n_push = 2'(h_emit) + 2'(v_emit);
   end

   // Memory port selection
   always_comb begin
      mem_we    = busy_ff || e_valid_ff;
      mem_waddr = busy_ff ? clr_cnt_ff : e_addr;
      mem_wdata = busy_ff ? '0 : v_cnt_new;
      mem_raddr = COL_AW'(q_item.col);
   end

   // Issue a read only when the buffer will have room for two results
   always_comb begin
      out_pop    = out_valid && !out_stall;
      out_cnt_in = out_cnt_ff + OUT_LW'(n_push) - OUT_LW'(out_pop);
      q_pop      = q_valid && !busy_ff && (out_cnt_in <= OUT_ROOM);
      wr_ptr_in  = wr_ptr_ff + OUT_AW'(n_push);
      rd_ptr_in  = rd_ptr_ff + OUT_AW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= vmem[mem_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         fwd_valid_ff <= 1'b0;
         e_valid_ff   <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_cnt_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         fwd_valid_ff <= e_valid_ff && !busy_ff;
         e_valid_ff   <= q_pop;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_addr_ff <= e_addr;
      fwd_data_ff <= v_cnt_new;
      if (q_pop) begin
         e_item_ff <= q_item;
      end
      if (h_emit) begin
         out_mem_ff[wr_ptr_ff] <= h_word;
         if (v_emit) begin
            out_mem_ff[wr_ptr_ff + OUT_AW'(1)] <= v_word;
         end
      end else if (v_emit) begin
         out_mem_ff[wr_ptr_ff] <= v_word;
      end
   end

   assign out_valid = out_cnt_ff != '0;
   assign out_word  = out_mem_ff[rd_ptr_ff];

endmodule

[hdl/hv_line_run_detector.sv]
// ---------------------------------------------------------------------------
// hv_line_run_detector: horizontal and vertical line-run detector
// Takes binary pixels in raster order and emits segment records for runs
// of set pixels that reach the programmed minimum lengths.
// ---------------------------------------------------------------------------
//  channel   ports                           direction  word
//  req       req_valid/req_stall             in         one pixel
//  rsp       rsp_valid/rsp_stall             out        one segment record
//  csr       psel/penable/pwrite/paddr/...   in/out     register access
//
//  One pixel per clock is accepted while req_stall is low; each pixel passes
//  through the queue, the column memory read and the result buffer in turn.
//  A pixel closing both runs yields two results, which the output port
//  drains at one per clock while rsp_stall is low.
//  After reset all 1024 column counter entries are cleared; req_stall
//  stays high until then. Register writes are taken at any time.
//  rsp_stall backs up through the result buffer and queue to req_stall.
// ---------------------------------------------------------------------------
module hv_line_run_detector import hvlrd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Pixel input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel_value,
   // Segment output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_direction,
   output logic [POS_W-1:0]   rsp_line_index,
   output logic [POS_W-1:0]   rsp_run_start,
   output logic [POS_W-1:0]   rsp_run_stop,
   output logic               rsp_last,
   // Register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type       cfg_ff;
   csr_addr_type  csr_sel;
   logic          csr_wr;
   logic          q_push;
   item_type      q_in_item;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   item_type      q_head;
   bk_status_type bk_status;
   result_type    rsp_word;

   // Register access
   assign pready  = 1'b1;
   assign csr_sel = csr_addr_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FRAME_WIDTH_RST;
         cfg_ff.frame_height <= FRAME_HEIGHT_RST;
         cfg_ff.h_min_run    <= H_MIN_RUN_RST;
         cfg_ff.v_min_run    <= V_MIN_RUN_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= pwdata[CNT_W-1:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= pwdata[CNT_W-1:0];
            CSR_H_MIN_RUN:    cfg_ff.h_min_run    <= pwdata[CNT_W-1:0];
            CSR_V_MIN_RUN:    cfg_ff.v_min_run    <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_FRAME_WIDTH:  prdata = 32'(cfg_ff.frame_width);
         CSR_FRAME_HEIGHT: prdata = 32'(cfg_ff.frame_height);
         CSR_H_MIN_RUN:    prdata = 32'(cfg_ff.h_min_run);
         CSR_V_MIN_RUN:    prdata = 32'(cfg_ff.v_min_run);
         default:          prdata = '0;
      endcase
   end

   hvlrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_valid),
      .in_pixel (req_pixel_value),
      .in_stall (req_stall),
      .busy     (bk_status.busy),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_in_item)
   );

   hvlrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head)
   );

   hvlrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .v_min_run (cfg_ff.v_min_run),
      .q_valid   (q_valid),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .status    (bk_status),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

   // Unpack the result word
   assign rsp_direction  = rsp_word.direction;
   assign rsp_line_index = rsp_word.line_index;
   assign rsp_run_start  = rsp_word.run_start;
   assign rsp_run_stop   = rsp_word.run_stop;
   assign rsp_last       = rsp_word.last;

   // Input must be held off while the column memory is swept
   a_stall_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input not stalled at start of memory sweep");

   // The read issue gate must keep the result buffer from overflowing
   a_out_level: assert property (@(posedge clock) disable iff (reset)
      bk_status.out_level <= OUT_LW'(OUT_DEPTH))
      else $error("result buffer overflow");

   // No result can exist before any pixel has been taken
   a_no_rsp_in_sweep: assert property (@(posedge clock) disable iff (reset)
      bk_status.busy |-> !rsp_valid)
      else $error("result offered during memory sweep");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for hv_line_run_detector
// Streams pixels in raster order, predicts the segment records that each
// pixel closes, and compares every record that leaves the block with the
// oldest prediction. Frame size and run minimums are reprogrammed between
// phases, and both sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
   import hvlrd_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_direction;
   logic [POS_W-1:0]   rsp_line_index;
   logic [POS_W-1:0]   rsp_run_start;
   logic [POS_W-1:0]   rsp_run_stop;
   logic               rsp_last;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   hv_line_run_detector u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_direction   (rsp_direction),
      .rsp_line_index  (rsp_line_index),
      .rsp_run_start   (rsp_run_start),
      .rsp_run_stop    (rsp_run_stop),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Pixels waiting to be sent, segments waiting to arrive
   logic [PIX_W-1:0] pixel_q[$];
   result_type       seg_q[$];
   int               err_count = 0;

   // Idling controls set per phase
   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;
   int hold_asked = 0;

   // Shadow of the programmed registers
   logic [CNT_W-1:0] cfg_width  = FRAME_WIDTH_RST;
   logic [CNT_W-1:0] cfg_height = FRAME_HEIGHT_RST;
   logic [CNT_W-1:0] cfg_hmin   = H_MIN_RUN_RST;
   logic [CNT_W-1:0] cfg_vmin   = V_MIN_RUN_RST;

   // Shadow of the scan position and run counters
   logic [POS_W-1:0] at_row = '0;
   logic [POS_W-1:0] at_col = '0;
   logic [CNT_W-1:0] h_len = '0;
   logic [CNT_W-1:0] v_len[MAX_WIDTH];

   initial begin
      foreach (v_len[i]) v_len[i] = '0;
   end

   initial begin
      forever #5 clock = ~clock;
   end

   // Frame size as the block sees it: 1..top
   function automatic int frame_limit(input logic [CNT_W-1:0] v, input int top);
      int r;
      r = v;
      if (r < 1) r = 1;
      if (r > top) r = top;
      return r;
   endfunction

   // First position covered by a run, floored at 0
   function automatic logic [POS_W-1:0] run_first(input int pos, input int len);
      return (len > pos) ? '0 : POS_W'(pos - len);
   endfunction

   // Work out the segments one pixel closes and advance the scan
   function automatic void predict_segments(input logic [PIX_W-1:0] pix);
      result_type found[2];
      int         w, h, row, col, n;
      bit         last_col, last_row;
      w = frame_limit(cfg_width, MAX_WIDTH);
      h = frame_limit(cfg_height, MAX_HEIGHT);
      row = at_row;
      col = at_col;
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      n = 0;
      if (pix == SET_PIXEL) begin
         if (h_len != CNT_MAX) h_len++;
         if (v_len[col] != CNT_MAX) v_len[col]++;
      end else begin
         if (h_len >= cfg_hmin) begin
            found[n] = '{DIR_HORZ, POS_W'(row), run_first(col, h_len), POS_W'(col), 1'b0};
            n++;
         end
         if (v_len[col] >= cfg_vmin) begin
            found[n] = '{DIR_VERT, POS_W'(col), run_first(row, v_len[col]), POS_W'(row),
                         1'b0};
            n++;
         end
         h_len = '0;
         v_len[col] = '0;
      end
      if (n > 0) found[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) seg_q.push_back(found[i]);
      // drop open runs at the end of a column or row
      if (last_row) v_len[col] = '0;
      if (last_col) begin
         h_len = '0;
         at_col = '0;
         at_row = last_row ? '0 : POS_W'(row + 1);
      end else begin
         at_col = POS_W'(col + 1);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         err_count++;
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   // Sender: score the word taken at this edge, then offer the next one
   int send_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_segments(req_pixel_value);
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               req_valid <= 1'b1;
               req_pixel_value <= pixel_q.pop_front();
               send_wait = send_idle ? $urandom_range(0, 11) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each word taken, then draw its own stall
   int rsp_wait = 0;
   int hold_left = 0;
   int hold_served = 0;
   always @(posedge clock) begin : rsp_side
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (seg_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected segment dir %0d line %0d start %0d stop %0d last %0d",
                        $time, rsp_direction, rsp_line_index, rsp_run_start, rsp_run_stop,
                        rsp_last);
            end else begin
               want = seg_q.pop_front();
               check_field("direction", want.direction, rsp_direction);
               check_field("line_index", want.line_index, rsp_line_index);
               check_field("run_start", want.run_start, rsp_run_start);
               check_field("run_stop", want.run_stop, rsp_run_stop);
               check_field("last", want.last, rsp_last);
            end
            rsp_wait = recv_idle ? $urandom_range(0, 11) : 0;
         end
         // long hold-off so the block backs up into its input
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_csr(input csr_addr_type idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = value[CNT_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[CNT_W-1:0];
         CSR_H_MIN_RUN:    cfg_hmin   = value[CNT_W-1:0];
         CSR_V_MIN_RUN:    cfg_vmin   = value[CNT_W-1:0];
      endcase
   endtask

   task automatic program_frame(input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] hm, input logic [31:0] vm);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_H_MIN_RUN, hm);
      write_csr(CSR_V_MIN_RUN, vm);
   endtask

   // Hold until every pixel is sent and every segment is back, then idle
   // while the pipeline clears
   task automatic settle();
      while (pixel_q.size() != 0 || req_valid || seg_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Queue a scene of horizontal and vertical stripes with broken pixels,
   // or plain noise, starting from the current scan position
   task automatic push_scene(input int count, input bit noisy);
      bit               col_on[MAX_WIDTH];
      bit               row_on[MAX_HEIGHT];
      int               w, h, c, r;
      logic [PIX_W-1:0] pix;
      w = frame_limit(cfg_width, MAX_WIDTH);
      h = frame_limit(cfg_height, MAX_HEIGHT);
      c = at_col;
      r = at_row;
      foreach (col_on[i]) col_on[i] = ($urandom_range(0, 4) < 2);
      foreach (row_on[i]) row_on[i] = ($urandom_range(0, 9) < 3);
      repeat (count) begin
         if (noisy) begin
            pix = $urandom_range(0, 1) ? SET_PIXEL : PIX_W'($urandom_range(0, 255));
         end else if ((col_on[c] || row_on[r]) && $urandom_range(0, 9) != 0) begin
            pix = SET_PIXEL;
         end else if ($urandom_range(0, 4) == 0) begin
            pix = SET_PIXEL;
         end else begin
            pix = PIX_W'($urandom_range(0, 254));
         end
         pixel_q.push_back(pix);
         if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            c++;
         end
      end
   endtask

   initial begin
      logic [31:0] w, h, hm, vm;
      int          n_items;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Small frame: runs closed mid-row, runs dropped at row and column end
      program_frame(4, 3, 2, 2);
      pixel_q = {8'hFF, 8'hFF, 8'h00, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFE,
                 8'h7F, 8'hFF, 8'h80, 8'h01};
      settle();

      // Shrink the frame mid-frame so a vertical run outgrows its row
      program_frame(2, 4, 32'h7FF, 1);
      pixel_q = {8'hFF, 8'hFF, 8'hFF};
      settle();
      write_csr(CSR_FRAME_HEIGHT, 2);
      pixel_q = {8'hFF, 8'h00};
      settle();

      // Zero minimums: an unset pixel closes a run in each direction
      write_csr(CSR_H_MIN_RUN, 0);
      write_csr(CSR_V_MIN_RUN, 0);
      pixel_q = {8'h00, 8'hFF};
      settle();

      // Frame sizes below and above range, with junk in the upper data bits
      program_frame(32'hFFFF_F800, 32'h7FF, 1, 1);
      pixel_q = {8'hFF, 8'h00, 8'hAA};
      settle();

      // Random phases, each with its own frame setup and idling
      for (int p = 0; p < 10; p++) begin
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 16);
         hm = $urandom_range(0, 6);
         vm = $urandom_range(0, 5);
         n_items = 60;
         send_idle = $urandom_range(0, 1);
         recv_idle = $urandom_range(0, 1);
         case (p)
            0: begin
               w = 8;
               h = 6;
               hm = 3;
               vm = 2;
               send_idle = 1'b0;
               recv_idle = 1'b0;
            end
            2: begin
               w = MAX_WIDTH;
               h = MAX_HEIGHT;
               hm = 1;
               vm = 1;
            end
            3: begin
               // zero minimums so unset pixels keep the result side busy
               w = 16;
               h = 12;
               hm = 0;
               vm = 0;
               send_idle = 1'b0;
               n_items = 100;
            end
            5: begin
               w = 32'h7FF;
               h = 0;
               hm = 2;
               vm = MAX_HEIGHT;
            end
            7: hm = MAX_WIDTH;
            default: ;
         endcase
         program_frame(w, h, hm, vm);
         if (p == 3) hold_asked++;
         push_scene(n_items, (p % 3) == 2);
         settle();
      end

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
hdl/hvlrd_pkg.sv
hdl/hvlrd_front.sv
hdl/hvlrd_queue.sv
hdl/hvlrd_back.sv
hdl/hv_line_run_detector.sv
tb/sv/testbench.sv
